@@ hdl/ctcr_pkg.sv @@
// Shared types, constants and the ambient-band target table for the cold tank request core.
`default_nettype none

package ctcr_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKE_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT_LEVEL = 1'd1;

  // Request types
  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_DISPENSE = 1'b1;

  // Temperatures in tenths of a degree
  localparam logic signed [11:0] TEMP_INIT_START = 12'sd230;
  localparam logic signed [11:0] PROTECT_TEMP    = 12'sd20;
  localparam logic signed [11:0] SLEEP_ON_TEMP   = 12'sd100;
  localparam logic signed [11:0] SPEED_HYST      = 12'sd5;
  localparam int                 BAND_STEP       = 40;
  localparam int                 NUM_BANDS       = 11;
  localparam logic [3:0]         HOT_BAND        = 4'd8;

  localparam logic [3:0]  ON_DELAY           = 4'd10;
  localparam logic [7:0]  AMOUNT_HOLD        = 8'd180;
  localparam logic [10:0] MIN_HELD_EXTRA     = 11'd180;
  localparam logic [6:0]  SPEED_RESET        = 7'd48;
  localparam logic [15:0] AMOUNT_LEVEL_RESET = 16'd240;

  typedef struct packed {
    logic                req_type;
    logic signed [11:0]  cold_temp;
    logic signed [11:0]  protect_temp;
    logic signed [11:0]  ambient_temp;
    logic                comp_running;
    logic                gas_to_cold;
    logic                cold_dispensing;
    logic                comp_rest_over;
    logic                make_inhibit;
    logic                sleep_mode;
    logic [15:0]         dispensed_amount;
  } in_word_t;

  typedef struct packed {
    logic       make_request;
    logic [6:0] target_speed;
    logic       temp_bad;
    logic       extra_cooling;
  } res_t;

  typedef struct packed {
    logic signed [11:0] on_tgt;
    logic signed [11:0] prt_on_tgt;
    logic signed [11:0] off_tgt;
    logic signed [11:0] speed_ref;
    logic [6:0]         rps_low;
    logic [6:0]         rps_high;
    logic [10:0]        extra;
  } row_t;

  function automatic row_t mk_row(input int on_v, input int prt_v, input int off_v,
                                  input int ref_v, input int lo_v, input int hi_v,
                                  input int ext_v);
    row_t r;
    r.on_tgt     = 12'(on_v);
    r.prt_on_tgt = 12'(prt_v);
    r.off_tgt    = 12'(off_v);
    r.speed_ref  = 12'(ref_v);
    r.rps_low    = 7'(lo_v);
    r.rps_high   = 7'(hi_v);
    r.extra      = 11'(ext_v);
    return r;
  endfunction

  // Row by start mode (0 init, 1 restart) and ambient band
  function automatic row_t tank_row(input logic mode, input logic [3:0] band);
    row_t r;
    if (!mode) begin
      case (band)
        4'd0:    r = mk_row( 35, -100, 20,  0, 45, 45,   90);
        4'd1:    r = mk_row( 40, -100, 25,  0, 47, 47,  150);
        4'd2:    r = mk_row( 45, -100, 30,  0, 47, 47,  210);
        4'd3:    r = mk_row( 50, -100, 35,  0, 47, 47,  240);
        4'd4:    r = mk_row( 60, -100, 40,  0, 47, 47,  330);
        4'd5:    r = mk_row( 70, -100, 50,  0, 47, 47,  480);
        4'd6:    r = mk_row( 75, -100, 50,  0, 47, 47,  540);
        4'd7:    r = mk_row( 80, -100, 50,  0, 47, 47,  660);
        4'd8:    r = mk_row(100, -100, 50,  0, 47, 47,  780);
        4'd9:    r = mk_row(125, -100, 55, 50, 60, 45,  990);
        default: r = mk_row(140, -100, 55, 50, 60, 45, 1050);
      endcase
    end else begin
      case (band)
        4'd0:    r = mk_row( 36, 35, 20,  0, 45, 45,   0);
        4'd1:    r = mk_row( 42, 38, 25,  0, 47, 47,  90);
        4'd2:    r = mk_row( 50, 40, 30,  0, 47, 47, 120);
        4'd3:    r = mk_row( 55, 41, 35,  0, 47, 47, 180);
        4'd4:    r = mk_row( 65, 43, 40,  0, 47, 47, 210);
        4'd5:    r = mk_row( 75, 46, 50,  0, 47, 47, 240);
        4'd6:    r = mk_row( 80, 48, 50,  0, 47, 47, 270);
        4'd7:    r = mk_row( 85, 50, 50,  0, 47, 47, 330);
        4'd8:    r = mk_row(105, 55, 50,  0, 47, 47, 360);
        4'd9:    r = mk_row(130, 63, 55, 55, 60, 45, 390);
        default: r = mk_row(145, 65, 55, 55, 60, 45, 420);
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cold_tank_compressor_request_core.sv @@
// Top level of the cold tank compressor request controller.
//
// One word in, one word out. A tick word (req_type 0) carries the cold, protection
// and ambient temperatures in signed tenths of a degree plus status flags; the
// core sorts ambient into eleven bands, looks up start/stop targets and extra-run
// time for init or restart mode, runs the start, stop, extra-cooling, sub-cool
// protection and speed hysteresis rules and returns make_request, target_speed,
// temp_bad and extra_cooling. A dispense word (req_type 1) only lowers the
// remaining cold-water budget (saturating at zero) and returns the current status.
// Rate: one word per clock sustained while the consumer keeps out_ready high. Each
// word is held in the input register and is then evaluated in a single pass
// against the state registers, which update on the same edge as the result
// register. The result waits in the result register, which drives out_*, until
// the consumer takes it. The input side keeps accepting while a result waits; it
// stalls only when both stages are full.
// Configuration (make_enable at index 0, amount_reset_level at index 1) is
// written through cfg_we/cfg_index/cfg_wdata and should only change while the
// core is idle. No clearing pass after reset: the core is ready straight away.
`default_nettype none

module cold_tank_compressor_request_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic signed [11:0]             in_cold_temp,
  input  logic signed [11:0]             in_protect_temp,
  input  logic signed [11:0]             in_ambient_temp,
  input  logic                           in_comp_running,
  input  logic                           in_gas_to_cold,
  input  logic                           in_cold_dispensing,
  input  logic                           in_comp_rest_over,
  input  logic                           in_make_inhibit,
  input  logic                           in_sleep_mode,
  input  logic [15:0]                    in_dispensed_amount,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_make_request,
  output logic [6:0]                     out_target_speed,
  output logic                           out_temp_bad,
  output logic                           out_extra_cooling,
  // configuration
  input  logic                           cfg_we,
  input  logic [ctcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import ctcr_pkg::*;

  in_word_t word_d;
  in_word_t word_q;
  res_t     res_d;
  res_t     res_q;
  logic     fire;
  logic     out_free;

  // pack the input word
  assign word_d.req_type         = in_req_type;
  assign word_d.cold_temp        = in_cold_temp;
  assign word_d.protect_temp     = in_protect_temp;
  assign word_d.ambient_temp     = in_ambient_temp;
  assign word_d.comp_running     = in_comp_running;
  assign word_d.gas_to_cold      = in_gas_to_cold;
  assign word_d.cold_dispensing  = in_cold_dispensing;
  assign word_d.comp_rest_over   = in_comp_rest_over;
  assign word_d.make_inhibit     = in_make_inhibit;
  assign word_d.sleep_mode       = in_sleep_mode;
  assign word_d.dispensed_amount = in_dispensed_amount;

  ctcr_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .word_d   (word_d),
    .dn_free  (out_free),
    .fire     (fire),
    .word_q   (word_q)
  );

  // state moves on the same edge the result is captured
  ctcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .wd        (word_q),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res_d)
  );

  ctcr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_d     (res_d),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .res_q     (res_q)
  );

  assign out_make_request  = res_q.make_request;
  assign out_target_speed  = res_q.target_speed;
  assign out_temp_bad      = res_q.temp_bad;
  assign out_extra_cooling = res_q.extra_cooling;

endmodule

`default_nettype wire

@@ hdl/ctcr_in_reg.sv @@
// Input register stage: holds one accepted word until the control stage takes it.
`default_nettype none

module ctcr_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctcr_pkg::in_word_t word_d,
  input  logic              dn_free,
  output logic              fire,
  output ctcr_pkg::in_word_t word_q
);

  logic               v_r;
  logic               v_nxt;
  ctcr_pkg::in_word_t word_r;

  assign fire     = v_r && dn_free;
  assign in_ready = !v_r || dn_free;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (fire) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_d;
    end
  end

  assign word_q = word_r;

endmodule

`default_nettype wire

@@ hdl/ctcr_ctrl.sv @@
// Control stage: per-tick rules, state registers and configuration registers.
`default_nettype none

module ctcr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  ctcr_pkg::in_word_t             wd,
  input  logic                           cfg_we,
  input  logic [ctcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output ctcr_pkg::res_t                 res
);
  import ctcr_pkg::*;

  // config
  logic        make_en_r;
  logic [15:0] level_r;

  // state
  logic        cr_r, cr_nxt;
  logic        ea_r, ea_nxt;
  logic [10:0] etl_r, etl_nxt;
  logic        retry_r, retry_nxt;
  logic        hp_r, hp_nxt;
  logic [10:0] ht_r, ht_nxt;
  logic        mode_r, mode_nxt;
  logic        cbh_r, cbh_nxt;
  logic [6:0]  spd_r, spd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [3:0]  dh_r, dh_nxt;
  logic        bad_r, bad_nxt;

  // working values
  logic signed [11:0] tc, tp, amb;
  logic [3:0]         band;
  row_t               row0, row1, row_f;
  logic signed [11:0] on0, on1, on_f;
  logic               hot_start, ibd_ret, rule_start, rule_stop, init_cond, mk;
  logic [3:0]         dh_eff;

  assign tc  = $signed(wd.cold_temp);
  assign tp  = $signed(wd.protect_temp);
  assign amb = $signed(wd.ambient_temp);

  // ambient band: number of 4.0 degree steps exceeded, capped at the last band
  always_comb begin
    band = 4'd0;
    for (int k = 1; k < NUM_BANDS; k++) begin
      if (amb > BAND_STEP * k) begin
        band = band + 4'd1;
      end
    end
  end

  assign row0 = tank_row(1'b0, band);
  assign row1 = tank_row(1'b1, band);
  assign on0  = wd.sleep_mode ? SLEEP_ON_TEMP : $signed(row0.on_tgt);
  assign on1  = wd.sleep_mode ? SLEEP_ON_TEMP : $signed(row1.on_tgt);

  assign hot_start = (tc >= TEMP_INIT_START);
  assign dh_eff    = wd.cold_dispensing ? ON_DELAY : dh_r;
  assign ibd_ret   = (dh_eff == 4'd0) && (rem_r == 16'd0);

  always_comb begin
    cr_nxt    = cr_r;
    ea_nxt    = ea_r;
    etl_nxt   = etl_r;
    retry_nxt = retry_r;
    hp_nxt    = hp_r;
    ht_nxt    = ht_r;
    mode_nxt  = mode_r;
    cbh_nxt   = cbh_r;
    spd_nxt   = spd_r;
    rem_nxt   = rem_r;
    hold_nxt  = hold_r;
    dh_nxt    = dh_r;
    bad_nxt   = bad_r;
    mk         = 1'b0;
    rule_start = 1'b0;
    rule_stop  = 1'b0;
    init_cond  = 1'b0;
    row_f      = mode_r ? row1 : row0;
    on_f       = wd.sleep_mode ? SLEEP_ON_TEMP : $signed(row_f.on_tgt);

    if (wd.req_type == REQ_TICK) begin
      if (wd.comp_running && wd.gas_to_cold && etl_r != 11'd0) begin
        etl_nxt = etl_r - 11'd1;
      end

      // budget hold and restore
      if (rem_r < level_r) begin
        if (hold_r == 8'd0) begin
          if (rem_r != 16'd0) begin
            rem_nxt  = level_r;
            hold_nxt = AMOUNT_HOLD;
          end
        end else begin
          hold_nxt = hold_r - 8'd1;
        end
      end

      if (ea_r) begin
        if (etl_nxt != 11'd0) begin
          mk = 1'b1;
        end else begin
          ea_nxt     = 1'b0;
          etl_nxt    = 11'd0;
          retry_nxt  = 1'b0;
          rule_start = 1'b1;
        end
      end else if (cr_r) begin
        rule_stop = 1'b1;
      end else begin
        rule_start = 1'b1;
      end

      // dispense hold only runs when a rule looks at it below the hot start
      if ((rule_start || rule_stop) && !hot_start && dh_eff != 4'd0) begin
        dh_nxt = dh_eff - 4'd1;
      end
      init_cond = (rule_start || rule_stop) && (hot_start || ibd_ret);

      if (rule_start) begin
        if (init_cond) begin
          mode_nxt = 1'b0;
          mk       = (tc >= on0);
          if (mk) begin
            hp_nxt = 1'b0;
            ht_nxt = 11'd0;
          end
        end else if (tp > PROTECT_TEMP) begin
          mode_nxt = 1'b1;
          if (tc >= on1 && tp >= $signed(row1.prt_on_tgt)) begin
            hp_nxt = 1'b0;
            ht_nxt = 11'd0;
            mk     = 1'b1;
          end else if (hp_r && wd.comp_rest_over) begin
            retry_nxt = 1'b1;
            ea_nxt    = 1'b1;
            etl_nxt   = ht_r;
            hp_nxt    = 1'b0;
            ht_nxt    = 11'd0;
          end
        end
      end

      if (rule_stop && init_cond) begin
        mode_nxt = 1'b0;
      end

      row_f = mode_nxt ? row1 : row0;
      on_f  = wd.sleep_mode ? SLEEP_ON_TEMP : $signed(row_f.on_tgt);

      if (rule_stop) begin
        mk = 1'b1;
        if ($signed(row_f.off_tgt) >= tc) begin
          ea_nxt  = 1'b1;
          etl_nxt = row_f.extra;
          if (row_f.extra == 11'd0) begin
            ea_nxt = 1'b0;
            mk     = 1'b0;
          end
        end
      end

      // sub-cool protection
      if (!(tp > PROTECT_TEMP)) begin
        if (band >= HOT_BAND) begin
          if (ea_nxt) begin
            if (!retry_nxt) begin
              if (etl_nxt >= MIN_HELD_EXTRA) begin
                hp_nxt = 1'b1;
                ht_nxt = etl_nxt;
              end
              ea_nxt    = 1'b0;
              etl_nxt   = 11'd0;
              retry_nxt = 1'b0;
              mk        = 1'b0;
            end
          end else if (mk) begin
            ea_nxt    = 1'b0;
            etl_nxt   = 11'd0;
            retry_nxt = 1'b0;
            hp_nxt    = 1'b0;
            ht_nxt    = 11'd0;
            mk        = 1'b0;
          end
        end else begin
          ea_nxt    = 1'b0;
          etl_nxt   = 11'd0;
          retry_nxt = 1'b0;
          hp_nxt    = 1'b0;
          ht_nxt    = 11'd0;
          mk        = 1'b0;
        end
      end

      // speed band hysteresis
      if (mk) begin
        if (!cbh_r) begin
          if ($signed(row_f.speed_ref) + SPEED_HYST <= tc) begin
            cbh_nxt = 1'b1;
          end
        end else if (tc < $signed(row_f.speed_ref)) begin
          cbh_nxt = 1'b0;
        end
        spd_nxt = cbh_nxt ? row_f.rps_high : row_f.rps_low;
      end

      if (!wd.comp_rest_over) begin
        mk = 1'b0;
      end
      if (!make_en_r || wd.make_inhibit) begin
        mk        = 1'b0;
        ea_nxt    = 1'b0;
        etl_nxt   = 11'd0;
        retry_nxt = 1'b0;
        hp_nxt    = 1'b0;
        ht_nxt    = 11'd0;
      end
      cr_nxt = mk;

      // water status
      if (make_en_r) begin
        if (!bad_r) begin
          if (tc >= on_f) begin
            bad_nxt = 1'b1;
          end
        end else if (tc <= $signed(row_f.off_tgt)) begin
          bad_nxt = 1'b0;
        end
      end
    end else begin
      rem_nxt = (rem_r < wd.dispensed_amount) ? 16'd0 : rem_r - wd.dispensed_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r    <= 1'b0;
      ea_r    <= 1'b0;
      etl_r   <= 11'd0;
      retry_r <= 1'b0;
      hp_r    <= 1'b0;
      ht_r    <= 11'd0;
      mode_r  <= 1'b1;
      cbh_r   <= 1'b1;
      spd_r   <= SPEED_RESET;
      rem_r   <= AMOUNT_LEVEL_RESET;
      hold_r  <= AMOUNT_HOLD;
      dh_r    <= 4'd0;
      bad_r   <= 1'b0;
    end else if (step) begin
      cr_r    <= cr_nxt;
      ea_r    <= ea_nxt;
      etl_r   <= etl_nxt;
      retry_r <= retry_nxt;
      hp_r    <= hp_nxt;
      ht_r    <= ht_nxt;
      mode_r  <= mode_nxt;
      cbh_r   <= cbh_nxt;
      spd_r   <= spd_nxt;
      rem_r   <= rem_nxt;
      hold_r  <= hold_nxt;
      dh_r    <= dh_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      make_en_r <= 1'b1;
      level_r   <= AMOUNT_LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAKE_ENABLE:  make_en_r <= cfg_wdata[0];
        CFG_AMOUNT_LEVEL: level_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign res.make_request  = cr_nxt;
  assign res.target_speed  = spd_nxt;
  assign res.temp_bad      = bad_nxt;
  assign res.extra_cooling = ea_nxt;

endmodule

`default_nettype wire

@@ hdl/ctcr_out_reg.sv @@
// Result register: holds one result word until the consumer takes it.
`default_nettype none

module ctcr_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  ctcr_pkg::res_t res_d,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           free,
  output ctcr_pkg::res_t res_q
);

  logic           ov_r;
  logic           ov_nxt;
  ctcr_pkg::res_t res_r;

  assign free = !ov_r || out_ready;

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_d;
    end
  end

  assign out_valid = ov_r;
  assign res_q     = res_r;

endmodule

`default_nettype wire

@@ hdl/ctcr_checker.sv @@
// Port-level checks for the cold tank request core, bound to the top level.
`default_nettype none

module ctcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_make_request,
  input logic [6:0] out_target_speed,
  input logic       out_temp_bad,
  input logic       out_extra_cooling
);
  import ctcr_pkg::*;

  localparam logic [6:0] RPS_A = 7'd45;
  localparam logic [6:0] RPS_B = 7'd47;
  localparam logic [6:0] RPS_C = 7'd60;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_make_request)
      && $stable(out_target_speed) && $stable(out_temp_bad) && $stable(out_extra_cooling))
    else $error("result word changed while stalled");

  // only table speeds or the reset speed ever reach the port
  a_speed_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_target_speed == RPS_A || out_target_speed == RPS_B
      || out_target_speed == RPS_C || out_target_speed == SPEED_RESET)
    else $error("target speed outside table");

  // input side stalls only when both stages are full
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result register");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind cold_tank_compressor_request_core ctcr_checker u_ctcr_checker (.*);

`default_nettype wire

@@ sim/tank_expect_pkg.sv @@
`timescale 1ns / 100ps
// Expected-status tracker for the cold tank request core: target table, state copy and checks.
package tank_expect_pkg;

  import ctcr_pkg::*;

  localparam int INIT_START     = 230;
  localparam int PROT_LIMIT     = 20;
  localparam int SLEEP_ON       = 100;
  localparam int DISP_DELAY     = 10;
  localparam int HOLD_TICKS     = 180;
  localparam int MIN_HELD       = 180;
  localparam int SPEED_AT_RESET = 48;
  localparam int HYST_TENTHS    = 5;
  localparam int FIRST_HOT_BAND = 8;
  localparam int LEVEL_AT_RESET = 240;

  typedef struct packed {
    int on;
    int prt_on;
    int off;
    int speed_ref;
    int rps_low;
    int rps_high;
    int extra;
  } tgt_row_t;

  // [init 0 / restart 1][ambient band]
  localparam tgt_row_t TANK_ROWS [2][11] = '{
    '{'{ 35, -100, 20,  0, 45, 45,   90}, '{ 40, -100, 25,  0, 47, 47,  150},
      '{ 45, -100, 30,  0, 47, 47,  210}, '{ 50, -100, 35,  0, 47, 47,  240},
      '{ 60, -100, 40,  0, 47, 47,  330}, '{ 70, -100, 50,  0, 47, 47,  480},
      '{ 75, -100, 50,  0, 47, 47,  540}, '{ 80, -100, 50,  0, 47, 47,  660},
      '{100, -100, 50,  0, 47, 47,  780}, '{125, -100, 55, 50, 60, 45,  990},
      '{140, -100, 55, 50, 60, 45, 1050}},
    '{'{ 36,   35, 20,  0, 45, 45,    0}, '{ 42,   38, 25,  0, 47, 47,   90},
      '{ 50,   40, 30,  0, 47, 47,  120}, '{ 55,   41, 35,  0, 47, 47,  180},
      '{ 65,   43, 40,  0, 47, 47,  210}, '{ 75,   46, 50,  0, 47, 47,  240},
      '{ 80,   48, 50,  0, 47, 47,  270}, '{ 85,   50, 50,  0, 47, 47,  330},
      '{105,   55, 50,  0, 47, 47,  360}, '{130,   63, 55, 55, 60, 45,  390},
      '{145,   65, 55, 55, 60, 45,  420}}
  };

  class request_tracker;
    bit        make_en;
    bit [15:0] budget_level;

    bit        comp_req, extra_on, extra_retry, held_pending;
    bit [10:0] extra_left, held_ticks;
    bit        restart_mode, band_high;
    bit [6:0]  speed;
    bit [15:0] budget;
    bit [7:0]  budget_hold;
    bit [3:0]  disp_hold;
    bit        status_bad;

    int        t_cold, t_prt, on_tgt, prt_on_tgt, off_tgt, band;
    bit        sleeping, rest_over, dispensing;
    tgt_row_t  row;

    res_t        pending_status[$];
    int unsigned mismatches;

    function new();
      restore();
      mismatches = 0;
    endfunction

    function void restore();
      make_en      = 1'b1;
      budget_level = 16'(LEVEL_AT_RESET);
      comp_req     = 1'b0;
      drop_extra();
      drop_held();
      restart_mode = 1'b1;
      band_high    = 1'b1;
      speed        = 7'(SPEED_AT_RESET);
      budget       = budget_level;
      budget_hold  = 8'(HOLD_TICKS);
      disp_hold    = '0;
      status_bad   = 1'b0;
      pending_status.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == CFG_MAKE_ENABLE) make_en = val[0];
      else if (idx == CFG_AMOUNT_LEVEL) budget_level = val;
    endfunction

    function void pick_row();
      row        = TANK_ROWS[restart_mode][band];
      on_tgt     = sleeping ? SLEEP_ON : row.on;
      prt_on_tgt = row.prt_on;
      off_tgt    = row.off;
    endfunction

    function void set_mode(bit m);
      restart_mode = m;
      pick_row();
    endfunction

    function void drop_extra();
      extra_on    = 1'b0;
      extra_left  = '0;
      extra_retry = 1'b0;
    endfunction

    function void drop_held();
      held_pending = 1'b0;
      held_ticks   = '0;
    endfunction

    // Empty budget starts from the init table, but not while a draw is recent
    function bit dispense_start();
      if (dispensing) disp_hold = 4'(DISP_DELAY);
      if (disp_hold != 0) begin
        disp_hold--;
        return 1'b0;
      end
      return budget == 0;
    endfunction

    function bit cold_start();
      if (t_cold >= INIT_START) return 1'b1;
      return dispense_start();
    endfunction

    function bit start_decision();
      if (cold_start()) begin
        set_mode(1'b0);
        if (t_cold >= on_tgt) begin
          drop_held();
          return 1'b1;
        end
        return 1'b0;
      end
      if (t_prt > PROT_LIMIT) begin
        set_mode(1'b1);
        if (t_cold >= on_tgt && t_prt >= prt_on_tgt) begin
          drop_held();
          return 1'b1;
        end
        if (held_pending && rest_over) begin
          extra_retry = 1'b1;
          extra_on    = 1'b1;
          extra_left  = held_ticks;
          drop_held();
        end
      end
      return 1'b0;
    endfunction

    function bit stop_decision();
      bit mk;
      mk = 1'b1;
      if (cold_start()) set_mode(1'b0);
      if (off_tgt >= t_cold) begin
        extra_on   = 1'b1;
        extra_left = 11'(row.extra);
        if (extra_left == 0) begin
          extra_on = 1'b0;
          mk       = 1'b0;
        end
      end
      return mk;
    endfunction

    function bit subcool_guard(bit mk);
      if (t_prt > PROT_LIMIT) return mk;
      if (band >= FIRST_HOT_BAND) begin
        if (extra_on) begin
          if (!extra_retry) begin
            if (extra_left >= MIN_HELD) begin
              held_pending = 1'b1;
              held_ticks   = extra_left;
            end
            drop_extra();
            mk = 1'b0;
          end
        end else if (mk) begin
          drop_extra();
          drop_held();
          mk = 1'b0;
        end
      end else begin
        drop_extra();
        drop_held();
        mk = 1'b0;
      end
      return mk;
    endfunction

    function bit [6:0] speed_pick();
      if (!band_high) begin
        if (row.speed_ref + HYST_TENTHS <= t_cold) band_high = 1'b1;
      end else if (t_cold < row.speed_ref) begin
        band_high = 1'b0;
      end
      return band_high ? 7'(row.rps_high) : 7'(row.rps_low);
    endfunction

    function void note_word(in_word_t w);
      res_t r;
      int   amb;
      bit   mk;
      if (w.req_type == REQ_TICK) begin
        t_cold     = $signed(w.cold_temp);
        t_prt      = $signed(w.protect_temp);
        amb        = $signed(w.ambient_temp);
        dispensing = w.cold_dispensing;
        rest_over  = w.comp_rest_over;
        sleeping   = w.sleep_mode;
        band = 0;
        while (band < 10 && amb > 40 * (band + 1)) band++;
        pick_row();

        if (w.comp_running && w.gas_to_cold && extra_left != 0) extra_left--;

        if (budget < budget_level) begin
          if (budget_hold == 0) begin
            if (budget != 0) begin
              budget      = budget_level;
              budget_hold = 8'(HOLD_TICKS);
            end
          end else begin
            budget_hold--;
          end
        end

        if (extra_on) begin
          if (extra_left != 0) begin
            mk = 1'b1;
          end else begin
            drop_extra();
            mk = start_decision();
          end
        end else begin
          mk = comp_req ? stop_decision() : start_decision();
        end
        mk = subcool_guard(mk);
        if (mk) speed = speed_pick();
        if (!rest_over) mk = 1'b0;
        if (!make_en || w.make_inhibit) begin
          mk = 1'b0;
          drop_extra();
          drop_held();
        end
        comp_req = mk;

        if (make_en) begin
          if (!status_bad) begin
            if (t_cold >= on_tgt) status_bad = 1'b1;
          end else if (t_cold <= off_tgt) begin
            status_bad = 1'b0;
          end
        end
      end else begin
        if (budget < w.dispensed_amount) budget = '0;
        else budget = budget - w.dispensed_amount;
      end
      r.make_request  = comp_req;
      r.target_speed  = speed;
      r.temp_bad      = status_bad;
      r.extra_cooling = extra_on;
      pending_status.push_back(r);
    endfunction

    function void check_status(res_t got);
      res_t want;
      if (pending_status.size() == 0) begin
        $error("result word with no status outstanding");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      if (got.make_request !== want.make_request) begin
        $error("make_request: expected %0d, got %0d", want.make_request, got.make_request);
        mismatches++;
      end
      if (got.target_speed !== want.target_speed) begin
        $error("target_speed: expected %0d, got %0d", want.target_speed, got.target_speed);
        mismatches++;
      end
      if (got.temp_bad !== want.temp_bad) begin
        $error("temp_bad: expected %0d, got %0d", want.temp_bad, got.temp_bad);
        mismatches++;
      end
      if (got.extra_cooling !== want.extra_cooling) begin
        $error("extra_cooling: expected %0d, got %0d", want.extra_cooling, got.extra_cooling);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Top-level testbench for the cold tank compressor request core.
module testbench;

  import ctcr_pkg::*;
  import tank_expect_pkg::*;

  // Cycles with no word moving on either side before the run is abandoned;
  // the longest legitimate lull is the deliberate receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 200;
  // Idle margin after every outstanding status has come back
  localparam int DRAIN_CYCLES   = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid, in_ready;
  in_word_t             offer;
  logic                 out_valid, out_ready;
  logic                 out_make_request;
  logic [6:0]           out_target_speed;
  logic                 out_temp_bad;
  logic                 out_extra_cooling;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  request_tracker tracker = new();

  // quiet: neither side idles; long_hold_req: ask the sink for one long stall
  bit quiet;
  bit long_hold_req;

  // Random-walk plant so that well-formed ticks resemble a real tank
  int walk_cold, walk_amb;

  int unsigned n_ticks, n_reports, n_checked, n_requests, n_extra, n_settings;

  cold_tank_compressor_request_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (offer.req_type),
    .in_cold_temp        (offer.cold_temp),
    .in_protect_temp     (offer.protect_temp),
    .in_ambient_temp     (offer.ambient_temp),
    .in_comp_running     (offer.comp_running),
    .in_gas_to_cold      (offer.gas_to_cold),
    .in_cold_dispensing  (offer.cold_dispensing),
    .in_comp_rest_over   (offer.comp_rest_over),
    .in_make_inhibit     (offer.make_inhibit),
    .in_sleep_mode       (offer.sleep_mode),
    .in_dispensed_amount (offer.dispensed_amount),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_make_request    (out_make_request),
    .out_target_speed    (out_target_speed),
    .out_temp_bad        (out_temp_bad),
    .out_extra_cooling   (out_extra_cooling),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly from the short range, now and then a long lull
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // flags = {running, gas_to_cold, dispensing, rest_over, inhibit, sleep}
  function automatic in_word_t tick_word(int cold, int prt, int amb, logic [5:0] flags);
    in_word_t w;
    w.req_type         = REQ_TICK;
    w.cold_temp        = 12'(cold);
    w.protect_temp     = 12'(prt);
    w.ambient_temp     = 12'(amb);
    {w.comp_running, w.gas_to_cold, w.cold_dispensing,
     w.comp_rest_over, w.make_inhibit, w.sleep_mode} = flags;
    w.dispensed_amount = 16'(~amb);
    return w;
  endfunction

  function automatic in_word_t report_word(logic [15:0] amount);
    in_word_t w;
    w = tick_word(-1, 0, 1250, 6'b101010);
    w.req_type         = REQ_DISPENSE;
    w.dispensed_amount = amount;
    return w;
  endfunction

  // Mostly plausible ticks following the walk, some dispense reports and
  // some raw bit noise
  function automatic in_word_t random_word();
    in_word_t    w;
    logic [63:0] raw;
    int          roll, delta, prt;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      case ($urandom_range(0, 9))
        0, 1:    w = report_word(16'($urandom));
        2, 3, 4: w = report_word(16'($urandom_range(0, 300)));
        default: w = report_word(16'($urandom_range(0, 40)));
      endcase
      w.cold_temp = 12'($urandom);
    end else if (roll < 16) begin
      raw = {$urandom, $urandom};
      w   = raw[$bits(in_word_t)-1:0];
    end else begin
      // cooling pulls the water down, standing still lets it warm up
      delta = tracker.comp_req ? $urandom_range(0, 16) : $urandom_range(0, 16);
      delta = tracker.comp_req ? delta - 12 : delta - 4;
      walk_cold += delta;
      if ($urandom_range(0, 99) < 4) walk_cold = $urandom_range(0, 300);
      if (walk_cold < -50) walk_cold = -50;
      if (walk_cold > 300) walk_cold = 300;
      if ($urandom_range(0, 99) < 3) begin
        walk_amb = $urandom_range(0, 500);
        walk_amb -= 50;
      end
      prt = $urandom_range(0, 60);
      prt = walk_cold + prt - 40;
      if ($urandom_range(0, 9) == 0) begin
        prt = $urandom_range(0, 60);
        prt = prt - 40;
      end
      w = tick_word(walk_cold, prt, walk_amb,
                    {$urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85,
                     $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 90,
                     $urandom_range(0, 99) < 3,  $urandom_range(0, 99) < 5});
    end
    return w;
  endfunction

  // Offer one word and hold it until taken; valid stays up for a
  // back-to-back word so it is never dropped and raised in one step.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    offer    <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(w);
    if (w.req_type == REQ_TICK) n_ticks++;
    else n_reports++;
  endtask

  // Stop offering and let every outstanding status come back, so the
  // core is idle for a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic enable, input logic [15:0] level);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAKE_ENABLE;
    cfg_wdata <= {15'd0, enable};
    @(posedge clk);
    tracker.write_reg(CFG_MAKE_ENABLE, {15'd0, enable});
    cfg_index <= CFG_AMOUNT_LEVEL;
    cfg_wdata <= level;
    @(posedge clk);
    tracker.write_reg(CFG_AMOUNT_LEVEL, level);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input logic enable, input logic [15:0] level, input int words,
                           input bit no_idle, input bit squeeze);
    settle();
    set_regs(enable, level);
    quiet = no_idle;
    if (squeeze) long_hold_req = 1'b1;
    repeat (words) send_word(random_word());
  endtask

  // Short directed opening, from reset values (make enabled, budget 240)
  task automatic directed_words();
    // field extremes, all flags both ways
    send_word(tick_word(-400, -400, -400, 6'b000000));
    send_word(tick_word(1250, 1250, 1250, 6'b111111));
    send_word(tick_word(-2048, 2047, -2048, 6'b010101));
    send_word(tick_word(2047, -2048, 2047, 6'b101010));
    // hot water forces an init start, then cool down to the off target
    send_word(tick_word(250, 30, 0, 6'b000100));
    send_word(tick_word(150, 30, 0, 6'b110100));
    send_word(tick_word(15, 30, 0, 6'b110100));
    // sub-cool with a cool ambient kills the extra run
    send_word(tick_word(15, 10, 0, 6'b110100));
    // hot ambient: extra run parked by sub-cool, then retried
    send_word(tick_word(250, 30, 400, 6'b000100));
    send_word(tick_word(40, 30, 400, 6'b110100));
    send_word(tick_word(40, 10, 400, 6'b110100));
    send_word(tick_word(40, 30, 400, 6'b000100));
    send_word(tick_word(40, 30, 400, 6'b110100));
    // sleep raises the on target to ten degrees
    send_word(tick_word(110, 30, 0, 6'b000101));
    send_word(tick_word(95, 30, 0, 6'b000101));
    // recent draw delays the empty-budget start
    send_word(tick_word(100, 30, 100, 6'b001100));
    // budget drained to zero, zero report, then empty-budget ticks
    send_word(report_word(16'hFFFF));
    send_word(report_word(16'h0000));
    send_word(tick_word(50, 30, 100, 6'b000100));
    send_word(tick_word(50, 30, 100, 6'b000100));
    // inhibit and rest-not-over both veto the request
    send_word(tick_word(250, 30, 0, 6'b000110));
    send_word(tick_word(250, 30, 0, 6'b110000));
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    offer         <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MAKE_ENABLE;
    cfg_wdata     <= '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    walk_cold     = 80;
    walk_amb      = 150;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed_words();

    // register settings, extremes included; the squeeze phase asks the
    // sink to hold off while words keep coming, so the core backs up
    run_phase(1'b1, 16'd240,              260, 1'b0, 1'b0);
    run_phase(1'b1, 16'hFFFF,             250, 1'b0, 1'b0);
    run_phase(1'b0, 16'h0000,             120, 1'b0, 1'b0);
    run_phase(1'b1, 16'd5,                250, 1'b0, 1'b0);
    run_phase(1'b1, 16'($urandom),        200, 1'b0, 1'b1);
    run_phase(1'b1, 16'd240,              150, 1'b1, 1'b0);
    settle();

    $display("Ran %0d tick words and %0d dispense reports across %0d register settings.",
             n_ticks, n_reports, n_settings);
    $display("Checked %0d results: %0d with a make request, %0d with extra cooling.",
             n_checked, n_requests, n_extra);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result sink: checks every accepted status word and throttles out_ready
  initial begin : result_sink
    int   stall_left;
    res_t got;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.make_request  = out_make_request;
        got.target_speed  = out_target_speed;
        got.temp_bad      = out_temp_bad;
        got.extra_cooling = out_extra_cooling;
        tracker.check_status(got);
        n_checked++;
        if (out_make_request) n_requests++;
        if (out_extra_cooling) n_extra++;
      end
      if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && rst_n && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) break;
    end
    $display("Watchdog: no word moved for %0d cycles, %0d statuses outstanding.",
             WATCHDOG_LIMIT, tracker.pending_status.size());
    $display("FAIL");
    $finish;
  end

endmodule
